### rtl/sc2a_pkg.sv
package sc2a_pkg;

  localparam int unsigned TABLE_ENTRIES = 89;
  localparam logic [2:0]  PAUSE_SKIP    = 3'd2;

  localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
  localparam logic [7:0] BYTE_PREFIX = 8'hE0;

  localparam logic [6:0] IDX_LSHIFT = 7'h2A;
  localparam logic [6:0] IDX_RSHIFT = 7'h36;
  localparam logic [6:0] IDX_CAPS   = 7'h3A;
  localparam logic [6:0] IDX_NUM    = 7'h45;
  localparam logic [6:0] IDX_SCROLL = 7'h46;

  localparam logic [6:0] IDX_SYM_LO = 7'd2;
  localparam logic [6:0] IDX_SYM_HI = 7'd53;
  localparam logic [6:0] IDX_PAD_LO = 7'd71;
  localparam logic [6:0] IDX_PAD_HI = 7'd83;

  localparam logic [7:0] KC_NONE  = 8'h00;
  localparam logic [7:0] KC_PAUSE = 8'hA0;

  localparam logic [7:0] ASCII_A_LO = 8'h61;
  localparam logic [7:0] ASCII_Z_LO = 8'h7A;

  typedef struct packed {
    logic [7:0] key_code;
    logic       pressed;
    logic       extended;
  } key_result_t;

  // {normal, shifted} per scan index
  localparam logic [15:0] KEY_MAP [0:TABLE_ENTRIES-1] = '{
    16'h0000, 16'h1B1B, 16'h3121, 16'h3240, 16'h3323, 16'h3424, 16'h3525, 16'h365E,
    16'h3726, 16'h382A, 16'h3928, 16'h3029, 16'h2D5F, 16'h3D2B, 16'h0808, 16'h0909,
    16'h7151, 16'h7757, 16'h6545, 16'h7252, 16'h7454, 16'h7959, 16'h7555, 16'h6949,
    16'h6F4F, 16'h7050, 16'h5B7B, 16'h5D7D, 16'h0A0A, 16'h8181, 16'h6141, 16'h7353,
    16'h6444, 16'h6646, 16'h6747, 16'h6848, 16'h6A4A, 16'h6B4B, 16'h6C4C, 16'h3B3A,
    16'h2722, 16'h607E, 16'h8282, 16'h5C7C, 16'h7A5A, 16'h7858, 16'h6343, 16'h7656,
    16'h6242, 16'h6E4E, 16'h6D4D, 16'h2C3C, 16'h2E3E, 16'h2F3F, 16'h8383, 16'h2A2A,
    16'h8585, 16'h2020, 16'h8686, 16'h8787, 16'h8888, 16'h8989, 16'h8A8A, 16'h8B8B,
    16'h8C8C, 16'h8D8D, 16'h8E8E, 16'h8F8F, 16'h9090, 16'h9191, 16'h9292, 16'h9337,
    16'h9438, 16'h9539, 16'h2D2D, 16'h9634, 16'h9735, 16'h9836, 16'h2B2B, 16'h9931,
    16'h9A32, 16'h9B33, 16'h9C30, 16'h9D2E, 16'h0000, 16'h0000, 16'h0000, 16'h9E9E,
    16'h9F9F
  };

  function automatic logic [7:0] key_lookup(logic [6:0] idx, logic col);
    logic [15:0] entry;
    entry = {KC_NONE, KC_NONE};
    if (32'(idx) < TABLE_ENTRIES) begin
      entry = KEY_MAP[idx];
    end
    return col ? entry[7:0] : entry[15:8];
  endfunction

endpackage

### rtl/sc2a_decoder.sv
module sc2a_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          scan_byte,
  output logic                produce,
  output sc2a_pkg::key_result_t result
);
  import sc2a_pkg::*;

  logic       shift_held, caps_lock_on, num_lock_on, scroll_lock_on, prefix_seen;
  logic [2:0] bytes_to_skip;

  logic [6:0] idx;
  logic       down, skipping, is_pause, is_prefix, is_letter, col;
  logic [7:0] normal_code;

  assign idx       = scan_byte[6:0];
  assign down      = ~scan_byte[7];
  assign skipping  = (bytes_to_skip != 3'd0);
  assign is_pause  = (scan_byte == BYTE_PAUSE);
  assign is_prefix = (scan_byte == BYTE_PREFIX);

  assign normal_code = key_lookup(idx, 1'b0);
  assign is_letter   = (normal_code >= ASCII_A_LO) && (normal_code <= ASCII_Z_LO);

  always_comb begin
    priority if (is_letter) begin
      col = shift_held ^ caps_lock_on;
    end else if (idx >= IDX_SYM_LO && idx <= IDX_SYM_HI) begin
      col = shift_held;
    end else if (idx >= IDX_PAD_LO && idx <= IDX_PAD_HI && !prefix_seen) begin
      col = num_lock_on;
    end else begin
      col = 1'b0;
    end
  end

  always_comb begin
    produce         = !skipping && !is_prefix;
    result.key_code = key_lookup(idx, col);
    result.pressed  = down;
    result.extended = prefix_seen;
    if (is_pause) begin
      result.key_code = KC_PAUSE;
      result.pressed  = 1'b1;
      result.extended = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      caps_lock_on   <= 1'b0;
      num_lock_on    <= 1'b0;
      scroll_lock_on <= 1'b0;
      prefix_seen    <= 1'b0;
      bytes_to_skip  <= 3'd0;
    end else if (fire) begin
      priority if (skipping) begin
        bytes_to_skip <= bytes_to_skip - 3'd1;
      end else if (is_pause) begin
        bytes_to_skip <= PAUSE_SKIP;
      end else if (is_prefix) begin
        prefix_seen <= 1'b1;
      end else begin
        prefix_seen <= 1'b0;
        // locks see the old state for this byte's own lookup
        priority if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
          shift_held <= down;
        end else if (idx == IDX_CAPS && down) begin
          caps_lock_on <= ~caps_lock_on;
        end else if (idx == IDX_NUM && down) begin
          num_lock_on <= ~num_lock_on;
        end else if (idx == IDX_SCROLL && down) begin
          scroll_lock_on <= ~scroll_lock_on;
        end else begin
          shift_held <= shift_held;
        end
      end
    end
  end

endmodule

### rtl/sc2a_out_stage.sv
module sc2a_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sc2a_pkg::key_result_t result,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata     // key_code[7:0], pressed[8], extended[9], zero
);
  import sc2a_pkg::*;

  logic        out_valid;
  key_result_t out_res;

  assign free     = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.extended, out_res.pressed, out_res.key_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_res <= result;
    end
  end

endmodule

### rtl/scan_code_to_ascii_converter_top.sv
// Set-1 keyboard scan byte to key code converter.
// Slave channel: one raw scan byte per transfer on s_tdata. Bit 7 set marks
// a key release. 0xE0 prefixes and the tail of the pause sequence give no
// result; every other byte gives exactly one result transfer.
// Master channel: key_code, pressed and extended packed in m_tdata.
// Path: a byte taken is held in the input register, decoded combinationally
// and registered in the result register, which drives m_tvalid and m_tdata.
// Throughput: one byte per cycle while m_tready stays high, set by the
// single decode step between the input register and the result register.
// A stalled receiver holds the result register; one more byte waits in the
// input register, and s_tready drops only once both are full.
// Reset (rst, synchronous) clears shift and lock state, the prefix flag,
// the pause skip count and both valid flags.
module scan_code_to_ascii_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // scan_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata     // key_code[7:0], pressed[8], extended[9], zero
);
  import sc2a_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_free, advance, produce;
  key_result_t result;

  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sc2a_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .scan_byte (in_byte),
    .produce   (produce),
    .result    (result)
  );

  sc2a_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && produce),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### rtl/sc2a_checker.sv
module sc2a_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import sc2a_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

  a_pause_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:0] == KC_PAUSE |-> m_tdata[8] && !m_tdata[9])
    else $error("pause key with wrong flags");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:10] == 6'd0)
    else $error("nonzero pad bits in result");

endmodule

bind scan_code_to_ascii_converter_top sc2a_checker u_sc2a_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
